/* design/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Field widths, mode codes, register indexes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // screen geometry defaults
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // item field widths
    localparam int MODE_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 8;
    localparam int IDX_W    = 11;
    localparam int CURSOR_W = 16;
    localparam int CELL_W   = 16;
    localparam int POS_W    = 11;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register indexes, taken from paddr[2]
    localparam logic REG_DEFAULT_COLOR = 1'b0;
    localparam logic REG_CURSOR_EN     = 1'b1;

    // reset values
    localparam logic [COLOR_W-1:0] DEFAULT_COLOR_RST = 8'h07;
    localparam logic               CURSOR_EN_RST     = 1'b1;

    // special characters and codes
    localparam logic [CHAR_W-1:0]   CH_BACKSPACE  = 8'h08;
    localparam logic [CHAR_W-1:0]   CH_NEWLINE    = 8'h0A;
    localparam logic [CHAR_W-1:0]   CH_SPACE      = 8'h20;
    localparam logic [CURSOR_W-1:0] HIDDEN_CURSOR = 16'hFFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUT   = 2'd0,
        MODE_COLOR = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;     // latch the accepted item
        logic clr_start;   // begin a clear walk
        logic clr_step;    // blank one cell in the clear color
        logic scr_start;   // begin a scroll, prime the first read
        logic scr_step;    // copy one cell up by a row
        logic blank_step;  // blank one cell of the bottom row
        logic bs;          // backspace
        logic nl;          // newline without scroll
        logic put;         // write character at position
        logic load_color;  // load active color
        logic rd_issue;    // read a cell
        logic rd_load;     // capture read data
        logic respond;     // load the output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        t_mode mode;
        logic  is_bs;
        logic  is_nl;
        logic  pos_zero;
        logic  pos_end;
        logic  pos_last_row;
        logic  idx_ok;
        logic  scr_last;
        logic  walk_end;
        logic  out_free;
    } t_stat;

endpackage

/* design/tcw_in_if.sv */
// ----------------------------------------------------------------------------
// tcw_in_if: input item channel
// Valid/ready handshake with the console command payload.
// ----------------------------------------------------------------------------
interface tcw_in_if;
    import tcw_pkg::*;

    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [CHAR_W-1:0]  char_code;
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   cell_index;

    modport source(output valid, mode, char_code, color, cell_index, input ready);
    modport sink(input valid, mode, char_code, color, cell_index, output ready);

endinterface

/* design/tcw_out_if.sv */
// ----------------------------------------------------------------------------
// tcw_out_if: result item channel
// Valid/ready handshake with cursor, cell and position payload.
// ----------------------------------------------------------------------------
interface tcw_out_if;
    import tcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [CURSOR_W-1:0] cursor_value;
    logic [CELL_W-1:0]   cell_data;
    logic [POS_W-1:0]    position;

    modport source(output valid, cursor_value, cell_data, position, input ready);
    modport sink(input valid, cursor_value, cell_data, position, output ready);

endinterface

/* design/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/tcw_ctrl.sv */
// ----------------------------------------------------------------------------
// tcw_ctrl: console controller
// One-hot state machine that sequences put, color, clear, read, the scroll
// and clear walks, and the result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tcw_pkg::t_stat i_stat,
    output tcw_pkg::t_cmd  o_cmd
);
    import tcw_pkg::*;

    typedef enum logic [8:0] {
        S_RSTCLR = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_EXEC   = 9'b000000100,
        S_READ   = 9'b000001000,
        S_SCROLL = 9'b000010000,
        S_BLANK  = 9'b000100000,
        S_WRITE  = 9'b001000000,
        S_CLEAR  = 9'b010000000,
        S_RESP   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register, reset starts the power-on clear walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RSTCLR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_RSTCLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.walk_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_RESP;
                case (i_stat.mode)
                    MODE_PUT: begin
                        if (i_stat.is_bs) begin
                            o_cmd.bs = !i_stat.pos_zero;
                        end else if (i_stat.is_nl) begin
                            if (i_stat.pos_last_row) begin
                                o_cmd.scr_start = 1'b1;
                                n_state         = S_SCROLL;
                            end else begin
                                o_cmd.nl = 1'b1;
                            end
                        end else if (i_stat.pos_end) begin
                            o_cmd.scr_start = 1'b1;
                            n_state         = S_SCROLL;
                        end else begin
                            o_cmd.put = 1'b1;
                        end
                    end
                    MODE_COLOR: begin
                        o_cmd.load_color = 1'b1;
                    end
                    MODE_CLEAR: begin
                        o_cmd.clr_start = 1'b1;
                        n_state         = S_CLEAR;
                    end
                    MODE_READ: begin
                        if (i_stat.idx_ok) begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_READ;
                        end
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.rd_load = 1'b1;
                n_state       = S_RESP;
            end
            S_SCROLL: begin
                o_cmd.scr_step = 1'b1;
                if (i_stat.scr_last) begin
                    n_state = S_BLANK;
                end
            end
            S_BLANK: begin
                o_cmd.blank_step = 1'b1;
                if (i_stat.walk_end) begin
                    n_state = i_stat.is_nl ? S_RESP : S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.put = 1'b1;
                n_state   = S_RESP;
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.walk_end) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.respond = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* design/tcw_dpath.sv */
// ----------------------------------------------------------------------------
// tcw_dpath: console datapath
// Screen store, write position and column, colors, walk counter and the
// output register, all driven by controller commands.
// ----------------------------------------------------------------------------
module tcw_dpath #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tcw_pkg::t_cmd                  i_cmd,
    output tcw_pkg::t_stat                 o_stat,
    input  logic [tcw_pkg::MODE_W-1:0]     i_mode,
    input  logic [tcw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [tcw_pkg::COLOR_W-1:0]    i_color,
    input  logic [tcw_pkg::IDX_W-1:0]      i_cell_index,
    input  logic [tcw_pkg::COLOR_W-1:0]    i_default_color,
    input  logic                           i_cursor_en,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [tcw_pkg::CURSOR_W-1:0]   o_cursor_value,
    output logic [tcw_pkg::CELL_W-1:0]     o_cell_data,
    output logic [tcw_pkg::POS_W-1:0]      o_position
);
    import tcw_pkg::*;

    localparam int CELL_COUNT     = COLUMNS * ROWS;
    localparam int LAST_ROW_START = COLUMNS * (ROWS - 1);
    localparam int ADDR_W         = $clog2(CELL_COUNT);
    localparam int PW             = $clog2(CELL_COUNT + 1);
    localparam int COL_W          = $clog2(COLUMNS);

    // item registers
    t_mode              r_mode;
    logic [CHAR_W-1:0]  r_char;
    logic [COLOR_W-1:0] r_color;
    logic [IDX_W-1:0]   r_idx;

    // console state
    logic [PW-1:0]      r_pos;
    logic [PW-1:0]      n_pos;
    logic [COL_W-1:0]   r_col;
    logic [COL_W-1:0]   n_col;
    logic [COLOR_W-1:0] r_active;
    logic [COLOR_W-1:0] r_clear_attr;
    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  n_addr;
    logic [CELL_W-1:0]  r_cell;

    // output register
    logic                r_out_valid;
    logic [CURSOR_W-1:0] r_out_cursor;
    logic [CELL_W-1:0]   r_out_cell;
    logic [POS_W-1:0]    r_out_pos;

    // ram ports
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [CELL_W-1:0] w_wdata;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;
    logic [CELL_W-1:0] w_rdata;

    tcw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELL_COUNT)
    ) u_screen (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // status toward the controller
    always_comb begin
        o_stat.mode         = r_mode;
        o_stat.is_bs        = (r_char == CH_BACKSPACE);
        o_stat.is_nl        = (r_char == CH_NEWLINE);
        o_stat.pos_zero     = (r_pos == '0);
        o_stat.pos_end      = (r_pos >= PW'(CELL_COUNT));
        o_stat.pos_last_row = (r_pos >= PW'(LAST_ROW_START));
        o_stat.idx_ok       = (32'(r_idx) < 32'(CELL_COUNT));
        o_stat.scr_last     = (r_addr == ADDR_W'(LAST_ROW_START - 1));
        o_stat.walk_end     = (r_addr == ADDR_W'(CELL_COUNT - 1));
        o_stat.out_free     = !r_out_valid || i_out_ready;
    end

    // store access selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = {r_clear_attr, CH_SPACE};
        w_re    = 1'b0;
        w_raddr = ADDR_W'(r_idx);
        if (i_cmd.clr_step) begin
            w_we = 1'b1;
        end
        if (i_cmd.blank_step) begin
            w_we    = 1'b1;
            w_wdata = {r_active, CH_SPACE};
        end
        // copy pipeline: write each cell with the cell below it, read one ahead
        if (i_cmd.scr_step) begin
            w_we    = 1'b1;
            w_wdata = w_rdata;
            w_re    = !o_stat.scr_last;
            w_raddr = r_addr + ADDR_W'(COLUMNS + 1);
        end
        if (i_cmd.scr_start) begin
            w_re    = 1'b1;
            w_raddr = ADDR_W'(COLUMNS);
        end
        if (i_cmd.bs) begin
            w_we    = 1'b1;
            w_waddr = ADDR_W'(r_pos - PW'(1));
            w_wdata = {r_active, CH_SPACE};
        end
        if (i_cmd.put) begin
            w_we    = 1'b1;
            w_waddr = ADDR_W'(r_pos);
            w_wdata = {r_active, r_char};
        end
        if (i_cmd.rd_issue) begin
            w_re = 1'b1;
        end
    end

    // position, column and walk counter next values
    always_comb begin
        n_pos  = r_pos;
        n_col  = r_col;
        n_addr = r_addr;
        if (i_cmd.clr_start || i_cmd.scr_start) begin
            n_addr = '0;
        end
        if (i_cmd.clr_step || i_cmd.scr_step || i_cmd.blank_step) begin
            n_addr = r_addr + ADDR_W'(1);
        end
        if (i_cmd.clr_start) begin
            n_pos = '0;
            n_col = '0;
        end
        if (i_cmd.scr_start) begin
            n_pos = PW'(LAST_ROW_START);
            n_col = '0;
        end
        if (i_cmd.bs) begin
            n_pos = r_pos - PW'(1);
            n_col = (r_col == '0) ? COL_W'(COLUMNS - 1) : r_col - COL_W'(1);
        end
        if (i_cmd.nl) begin
            n_pos = r_pos - PW'(r_col) + PW'(COLUMNS);
            n_col = '0;
        end
        if (i_cmd.put) begin
            n_pos = r_pos + PW'(1);
            n_col = (r_col == COL_W'(COLUMNS - 1)) ? '0 : r_col + COL_W'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_col        <= '0;
            r_addr       <= '0;
            r_active     <= DEFAULT_COLOR_RST;
            r_clear_attr <= DEFAULT_COLOR_RST;
            r_out_valid  <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_col  <= n_col;
            r_addr <= n_addr;
            if (i_cmd.clr_start) begin
                r_active     <= i_default_color;
                r_clear_attr <= i_default_color;
            end else if (i_cmd.load_color) begin
                r_active <= r_color;
            end
            if (i_cmd.respond) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= t_mode'(i_mode);
            r_char  <= i_char_code;
            r_color <= i_color;
            r_idx   <= i_cell_index;
            r_cell  <= '0;
        end else if (i_cmd.rd_load) begin
            r_cell <= w_rdata;
        end
        if (i_cmd.respond) begin
            r_out_cursor <= i_cursor_en ? CURSOR_W'(r_pos) : HIDDEN_CURSOR;
            r_out_cell   <= r_cell;
            r_out_pos    <= POS_W'(r_pos);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cursor_value = r_out_cursor;
    assign o_cell_data    = r_out_cell;
    assign o_position     = r_out_pos;

endmodule

/* design/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// Put character, set color, clear and read cell over a COLUMNS x ROWS store
// of 16-bit cells, with scroll on overflow and an APB register port.
// ----------------------------------------------------------------------------
// Each item is captured, executed and answered by a respond step that loads
// the output register. A cell read adds a read-data capture step; a scroll
// adds the copy and blank walks, then the character write unless the item is
// a newline; a clear adds the blank walk over all COLUMNS*ROWS cells.
// One item is taken at a time: the next is accepted only after the respond
// step, which waits while a pending result has not been taken.
// Reset: synchronous; the store is then blanked in color 0x07 by a walk over
// all COLUMNS*ROWS cells during which no item is taken.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tcw_in_if.sink                            i_in,
    tcw_out_if.source                         o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import tcw_pkg::*;

    logic [COLOR_W-1:0] r_default_color;
    logic               r_cursor_en;
    logic               w_cfg_wr;
    logic               w_in_ready;
    t_cmd               w_cmd;
    t_stat              w_stat;

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_color <= DEFAULT_COLOR_RST;
            r_cursor_en     <= CURSOR_EN_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_DEFAULT_COLOR: r_default_color <= pwdata[COLOR_W-1:0];
                REG_CURSOR_EN:     r_cursor_en     <= pwdata[0];
                default:           r_cursor_en     <= r_cursor_en;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[2])
            REG_DEFAULT_COLOR: prdata = APB_DATA_W'(r_default_color);
            REG_CURSOR_EN:     prdata = APB_DATA_W'(r_cursor_en);
            default:           prdata = '0;
        endcase
    end

    // controller
    tcw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in.valid),
        .o_in_ready(w_in_ready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    assign i_in.ready = w_in_ready;

    // datapath
    tcw_dpath #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_mode         (i_in.mode),
        .i_char_code    (i_in.char_code),
        .i_color        (i_in.color),
        .i_cell_index   (i_in.cell_index),
        .i_default_color(r_default_color),
        .i_cursor_en    (r_cursor_en),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_cursor_value (o_out.cursor_value),
        .o_cell_data    (o_out.cell_data),
        .o_position     (o_out.position)
    );

    // one item in flight: no second accept right after an accept
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("item accepted while previous item still in work");

    // no store write while waiting for an item
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_ready |-> !(w_cmd.clr_step || w_cmd.scr_step || w_cmd.blank_step
                         || w_cmd.bs || w_cmd.put))
        else $error("store written while idle");

    // a new result only comes from a respond command
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_cmd.respond))
        else $error("result raised without respond command");

    // the respond command is only given when the output slot is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.respond |-> (!o_out.valid || o_out.ready))
        else $error("pending result overwritten");

endmodule
